FILE: hdl/tcpq_pkg.sv
// ----------------------------------------------------------------------------
// tcpq_pkg
// Shared types and codes for the three-class stable priority queue.
// ----------------------------------------------------------------------------
package tcpq_pkg;

  localparam int ID_W  = 16;
  localparam int CLS_W = 2;
  localparam int CMD_W = 2;
  localparam int ST_W  = 3;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SERVE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LIST   = 2'd2;

  localparam logic [ST_W-1:0] STS_INSERTED = 3'd0;
  localparam logic [ST_W-1:0] STS_FULL     = 3'd1;
  localparam logic [ST_W-1:0] STS_SERVED   = 3'd2;
  localparam logic [ST_W-1:0] STS_EMPTY    = 3'd3;
  localparam logic [ST_W-1:0] STS_LISTED   = 3'd4;
  localparam logic [ST_W-1:0] STS_NONE     = 3'd5;

  localparam int NUM_CLS = 3;

  typedef logic [1:0] cidx_t;

  // one queue operation per cycle at most
  typedef struct packed {
    logic  push;
    logic  pop;
    cidx_t cidx;
  } op_t;

endpackage

FILE: hdl/tcpq_if.sv
// ----------------------------------------------------------------------------
// tcpq_in_if / tcpq_out_if
// Valid/ready channels carrying command items and result items.
// ----------------------------------------------------------------------------
interface tcpq_in_if;
  import tcpq_pkg::*;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [ID_W-1:0]  entry_id;
  logic [CLS_W-1:0] entry_class;

  modport source (output valid, command, entry_id, entry_class, input ready);
  modport sink   (input valid, command, entry_id, entry_class, output ready);
endinterface

interface tcpq_out_if;
  import tcpq_pkg::*;
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [ID_W-1:0]  out_id;
  logic [CLS_W-1:0] out_class;
  logic             last;

  modport source (output valid, status, out_id, out_class, last, input ready);
  modport sink   (input valid, status, out_id, out_class, last, output ready);
endinterface

FILE: hdl/three_class_stable_priority_queue.sv
// ----------------------------------------------------------------------------
// three_class_stable_priority_queue
// Priority queue of up to DEPTH ids in three classes, stable within a class.
// ----------------------------------------------------------------------------
// Entries live in one RAM split into three circular regions, one per class;
// the order of service is class 1, then 2, then 3, each oldest first. An
// insert's result goes straight to the output register; an unused command
// is taken but gives no result. A serve reads the head id from the RAM,
// then loads it into the output register. A list moves to ST_LSEL, then
// for each waiting entry reads it from the single RAM read port in ST_LSEL
// and loads it in ST_DATA, passing over in ST_LSEL each empty class on the
// way to the last entry (at most two). A new item is taken only once the
// previous one has been fully handed to the output register, and not while
// the result channel is stalled.
module three_class_stable_priority_queue #(
  parameter int DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  tcpq_in_if.sink             in_ch,
  tcpq_out_if.source          out_ch
);
  import tcpq_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int MD = NUM_CLS * DEPTH;
  localparam int AW = (MD > 1) ? $clog2(MD) : 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LSEL = 3'b010,
    ST_DATA = 3'b100
  } state_t;

  state_t         st_r, st_nxt;
  cidx_t          lc_r, lc_nxt;
  logic [CW-1:0]  lidx_r, lidx_nxt;
  logic [CW-1:0]  ltot_r, ltot_nxt;
  logic [ST_W-1:0]  dstat_r, dstat_nxt;
  logic [CLS_W-1:0] dcls_r, dcls_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]  out_status_r, out_status_nxt;
  logic [ID_W-1:0]  out_id_r, out_id_nxt;
  logic [CLS_W-1:0] out_class_r, out_class_nxt;
  logic             out_last_r, out_last_nxt;

  logic [PW-1:0] head [NUM_CLS];
  logic [PW-1:0] tail [NUM_CLS];
  logic [CW-1:0] cnt  [NUM_CLS];
  logic [CW-1:0] total;

  op_t            op;
  logic           accept;
  logic           out_free;
  logic           full;
  cidx_t          in_cidx;
  cidx_t          sc;
  logic           lhit;
  logic [CW:0]    lsum;
  logic [PW-1:0]  lptr;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic           ram_re;
  logic [AW-1:0]  ram_raddr;
  logic [ID_W-1:0] ram_rdata;

  function automatic logic [AW-1:0] mk_addr(input cidx_t c, input logic [PW-1:0] p);
    return AW'(c) * AW'(DEPTH) + AW'(p);
  endfunction

  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (st_r == ST_IDLE) && out_free;
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = (total == CW'(DEPTH));
  assign in_cidx     = (in_ch.entry_class == '0) ? cidx_t'(2) : in_ch.entry_class - 2'd1;
  assign sc          = (cnt[0] != '0) ? cidx_t'(0) : ((cnt[1] != '0) ? cidx_t'(1) : cidx_t'(2));

  assign op.push = accept && (in_ch.command == CMD_INSERT) && !full;
  assign op.pop  = accept && (in_ch.command == CMD_SERVE) && (total != '0);
  assign op.cidx = (in_ch.command == CMD_INSERT) ? in_cidx : sc;

  assign lhit = (st_r == ST_LSEL) && (lidx_r < cnt[lc_r]);
  assign lsum = (CW+1)'(head[lc_r]) + (CW+1)'(lidx_r);
  assign lptr = (lsum >= (CW+1)'(DEPTH)) ? PW'(lsum - (CW+1)'(DEPTH)) : PW'(lsum);

  assign ram_we    = op.push;
  assign ram_waddr = mk_addr(in_cidx, tail[in_cidx]);
  assign ram_re    = op.pop || lhit;
  assign ram_raddr = op.pop ? mk_addr(sc, head[sc]) : mk_addr(lc_r, lptr);

  tcpq_ptrs #(.DEPTH(DEPTH)) u_ptrs (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (op),
    .head  (head),
    .tail  (tail),
    .cnt   (cnt),
    .total (total)
  );

  tcpq_ram #(.WIDTH(ID_W), .DEPTH(MD)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_ch.entry_id),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    st_nxt         = st_r;
    lc_nxt         = lc_r;
    lidx_nxt       = lidx_r;
    ltot_nxt       = ltot_r;
    dstat_nxt      = dstat_r;
    dcls_nxt       = dcls_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_class_nxt  = out_class_r;
    out_last_nxt   = out_last_r;

    case (st_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_ch.command)
            CMD_INSERT: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = full ? STS_FULL : STS_INSERTED;
              out_id_nxt     = '0;
              out_class_nxt  = '0;
              out_last_nxt   = 1'b1;
            end
            CMD_SERVE: begin
              if (total == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STS_EMPTY;
                out_id_nxt     = '0;
                out_class_nxt  = '0;
                out_last_nxt   = 1'b1;
              end else begin
                dstat_nxt = STS_SERVED;
                dcls_nxt  = sc + 2'd1;
                ltot_nxt  = CW'(1);
                st_nxt    = ST_DATA;
              end
            end
            CMD_LIST: begin
              if (total == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STS_NONE;
                out_id_nxt     = '0;
                out_class_nxt  = '0;
                out_last_nxt   = 1'b1;
              end else begin
                lc_nxt   = '0;
                lidx_nxt = '0;
                ltot_nxt = total;
                st_nxt   = ST_LSEL;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_LSEL: begin
        if (lhit) begin
          dstat_nxt = STS_LISTED;
          dcls_nxt  = lc_r + 2'd1;
          lidx_nxt  = lidx_r + CW'(1);
          st_nxt    = ST_DATA;
        end else begin
          lc_nxt   = lc_r + 2'd1;
          lidx_nxt = '0;
        end
      end
      ST_DATA: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = dstat_r;
          out_id_nxt     = ram_rdata;
          out_class_nxt  = dcls_r;
          out_last_nxt   = (ltot_r == CW'(1));
          ltot_nxt       = ltot_r - CW'(1);
          st_nxt         = (ltot_r == CW'(1)) ? ST_IDLE : ST_LSEL;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
      lc_r        <= '0;
      lidx_r      <= '0;
      ltot_r      <= '0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      lc_r        <= lc_nxt;
      lidx_r      <= lidx_nxt;
      ltot_r      <= ltot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dstat_r      <= dstat_nxt;
    dcls_r       <= dcls_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_class_r  <= out_class_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.out_id    = out_id_r;
  assign out_ch.out_class = out_class_r;
  assign out_ch.last      = out_last_r;

endmodule

FILE: hdl/tcpq_ram.sv
// ----------------------------------------------------------------------------
// tcpq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcpq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 192
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/tcpq_ptrs.sv
// ----------------------------------------------------------------------------
// tcpq_ptrs
// Head, tail and fill count of the three per-class circular regions.
// ----------------------------------------------------------------------------
module tcpq_ptrs #(
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  tcpq_pkg::op_t                         op,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] head [tcpq_pkg::NUM_CLS],
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] tail [tcpq_pkg::NUM_CLS],
  output logic [$clog2(DEPTH+1)-1:0]            cnt  [tcpq_pkg::NUM_CLS],
  output logic [$clog2(DEPTH+1)-1:0]            total
);
  import tcpq_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [PW-1:0] head_r [NUM_CLS];
  logic [PW-1:0] tail_r [NUM_CLS];
  logic [CW-1:0] cnt_r  [NUM_CLS];
  logic [CW-1:0] total_r;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CLS; c++) begin
        head_r[c] <= '0;
        tail_r[c] <= '0;
        cnt_r[c]  <= '0;
      end
      total_r <= '0;
    end else if (op.push) begin
      tail_r[op.cidx] <= wrap_inc(tail_r[op.cidx]);
      cnt_r[op.cidx]  <= cnt_r[op.cidx] + CW'(1);
      total_r         <= total_r + CW'(1);
    end else if (op.pop) begin
      head_r[op.cidx] <= wrap_inc(head_r[op.cidx]);
      cnt_r[op.cidx]  <= cnt_r[op.cidx] - CW'(1);
      total_r         <= total_r - CW'(1);
    end
  end

  assign head  = head_r;
  assign tail  = tail_r;
  assign cnt   = cnt_r;
  assign total = total_r;

endmodule

FILE: hdl/tcpq_checker.sv
// ----------------------------------------------------------------------------
// tcpq_checker
// Port-level checks on the result channel of the priority queue.
// ----------------------------------------------------------------------------
module tcpq_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [tcpq_pkg::ST_W-1:0]  status,
  input logic [tcpq_pkg::ID_W-1:0]  out_id,
  input logic [tcpq_pkg::CLS_W-1:0] out_class,
  input logic                       last
);
  import tcpq_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_id)
      && $stable(out_class) && $stable(last))
    else $error("result item changed while stalled");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != STS_LISTED) |-> last)
    else $error("single result item without last mark");

  a_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == STS_INSERTED || status == STS_FULL ||
                  status == STS_EMPTY || status == STS_NONE)
      |-> (out_id == '0) && (out_class == '0))
    else $error("status-only result carries an entry");

  a_entry_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == STS_SERVED || status == STS_LISTED) |-> out_class != '0)
    else $error("entry result with class zero");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> status <= STS_NONE)
    else $error("unknown status code");

endmodule

bind three_class_stable_priority_queue tcpq_checker u_tcpq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .status    (out_ch.status),
  .out_id    (out_ch.out_id),
  .out_class (out_ch.out_class),
  .last      (out_ch.last)
);
